[rtl/nqbs_pkg.sv]
// ----------------------------------------------------------------------------
// nqbs_pkg
// Shared sizes and types for the N-queens backtracking solver.
// ----------------------------------------------------------------------------
package nqbs_pkg;

  localparam int MAX_N  = 8;
  localparam int DIAG_N = 2 * MAX_N - 1;
  localparam int IDX_W  = $clog2(MAX_N);
  localparam int CNT_W  = $clog2(MAX_N + 1);
  localparam int DIAG_W = $clog2(DIAG_N);

  localparam logic [CNT_W-1:0] BOARD_RESET = CNT_W'(MAX_N);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic clear_all;
    logic set;
    logic clr;
    idx_t row;
    idx_t col;
  } flag_cmd_t;

endpackage

[rtl/nqbs_safety.sv]
// ----------------------------------------------------------------------------
// nqbs_safety
// Row and diagonal occupancy flags with the shared conflict check.
// ----------------------------------------------------------------------------
module nqbs_safety import nqbs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cnt_t      n,
  input  flag_cmd_t cmd,
  input  idx_t      try_row,
  input  idx_t      try_col,
  output logic      safe
);

  logic [MAX_N-1:0]  row_used;
  logic [DIAG_N-1:0] sum_used;
  logic [DIAG_N-1:0] diff_used;

  logic [DIAG_W-1:0] try_sum;
  logic [DIAG_W-1:0] try_diff;
  logic [DIAG_W-1:0] cmd_sum;
  logic [DIAG_W-1:0] cmd_diff;

  function automatic logic [DIAG_W-1:0] diff_idx(idx_t r, idx_t c, cnt_t nn);
    logic [DIAG_W:0] t;
    t = (DIAG_W + 1)'(r) + (DIAG_W + 1)'(nn) - (DIAG_W + 1)'(1) - (DIAG_W + 1)'(c);
    return t[DIAG_W-1:0];
  endfunction

  assign try_sum  = DIAG_W'(try_row) + DIAG_W'(try_col);
  assign try_diff = diff_idx(try_row, try_col, n);
  assign cmd_sum  = DIAG_W'(cmd.row) + DIAG_W'(cmd.col);
  assign cmd_diff = diff_idx(cmd.row, cmd.col, n);

  assign safe = !row_used[try_row] && !sum_used[try_sum] && !diff_used[try_diff];

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      row_used  <= '0;
      sum_used  <= '0;
      diff_used <= '0;
    end else if (cmd.set || cmd.clr) begin
      row_used[cmd.row]  <= cmd.set;
      sum_used[cmd_sum]  <= cmd.set;
      diff_used[cmd_diff] <= cmd.set;
    end
  end

endmodule

[rtl/n_queens_backtrack_solver.sv]
// ----------------------------------------------------------------------------
// n_queens_backtrack_solver
// Depth-first N-queens search, one candidate row tested per cycle by a shared
// conflict check; answer streamed one word per column, or one not-found word.
// Sequence: start_column is first reduced below n by repeated subtraction,
// then each row tried or backtrack step is taken in turn (data dependent),
// then the result words are emitted. Throughput: one request at a time.
// Reset: board_size returns to 8, flags clear, sequencer idle, no output.
// ----------------------------------------------------------------------------
module n_queens_backtrack_solver import nqbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  start_column,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  column,
  output logic [2:0]  queen_row,
  output logic        found,
  output logic        last
);

  typedef enum logic [1:0] {S_IDLE, S_NORM, S_SEARCH, S_EMIT} state_t;

  state_t    state;
  cnt_t      board_size;
  cnt_t      n;
  idx_t      start;
  cnt_t      depth;
  idx_t      col;
  cnt_t      row_try;
  logic      fail;
  cnt_t      ecol;
  idx_t      eptr;
  idx_t      stack [MAX_N];

  flag_cmd_t cmd;
  logic      safe;
  idx_t      rd_addr;
  idx_t      stack_row;
  idx_t      prev_col;
  idx_t      next_col;
  cnt_t      n_eff;
  logic      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(board_size);
  assign in_stall = (state != S_IDLE);

  assign n_eff = (board_size == '0) ? cnt_t'(1) :
                 (board_size > cnt_t'(MAX_N)) ? cnt_t'(MAX_N) : board_size;

  assign rd_addr   = (state == S_EMIT) ? eptr : idx_t'(depth - cnt_t'(1));
  assign stack_row = stack[rd_addr];
  assign prev_col  = (col == '0) ? idx_t'(n - cnt_t'(1)) : idx_t'(col - idx_t'(1));
  assign next_col  = (cnt_t'(col) + cnt_t'(1) == n) ? '0 : idx_t'(col + idx_t'(1));

  always_comb begin
    cmd = '0;
    cmd.col = col;
    cmd.row = row_try[IDX_W-1:0];
    unique case (state)
      S_IDLE: cmd.clear_all = in_valid;
      S_SEARCH: begin
        if (depth != n) begin
          if (row_try < n) begin
            cmd.set = safe;
          end else if (depth != '0) begin
            cmd.clr = 1'b1;
            cmd.row = stack_row;
            cmd.col = prev_col;
          end
        end
      end
      default: cmd = '0;
    endcase
  end

  nqbs_safety u_safety (
    .clk     (clk),
    .rst     (rst),
    .n       (n),
    .cmd     (cmd),
    .try_row (row_try[IDX_W-1:0]),
    .try_col (col),
    .safe    (safe)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      board_size <= BOARD_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        board_size <= pwdata[CNT_W-1:0];
      end
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            n     <= n_eff;
            start <= start_column;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (cnt_t'(start) >= n) begin
            start <= idx_t'(cnt_t'(start) - n);
          end else begin
            col     <= start;
            depth   <= '0;
            row_try <= '0;
            state   <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (depth == n) begin
            fail  <= 1'b0;
            ecol  <= '0;
            eptr  <= (start == '0) ? '0 : idx_t'(n - cnt_t'(start));
            state <= S_EMIT;
          end else if (row_try < n) begin
            if (safe) begin
              stack[depth[IDX_W-1:0]] <= row_try[IDX_W-1:0];
              depth   <= depth + cnt_t'(1);
              col     <= next_col;
              row_try <= '0;
            end else begin
              row_try <= row_try + cnt_t'(1);
            end
          end else if (depth == '0) begin
            fail  <= 1'b1;
            state <= S_EMIT;
          end else begin
            depth   <= depth - cnt_t'(1);
            col     <= prev_col;
            row_try <= cnt_t'(stack_row) + cnt_t'(1);
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            if (fail) begin
              column    <= '0;
              queen_row <= '0;
              found     <= 1'b0;
              last      <= 1'b1;
              state     <= S_IDLE;
            end else begin
              column    <= ecol[2:0];
              queen_row <= stack_row;
              found     <= 1'b1;
              last      <= (ecol + cnt_t'(1) == n);
              eptr      <= (cnt_t'(eptr) + cnt_t'(1) == n) ? '0 : idx_t'(eptr + idx_t'(1));
              ecol      <= ecol + cnt_t'(1);
              if (ecol + cnt_t'(1) == n) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the N-queens backtracking solver. Solve requests
// are sent over the valid/stall input channel while board_size is changed
// through the APB port between phases. Every answer word is compared field
// by field against a fixed word or a backtracking search inside the bench,
// with random gaps and stalls on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import nqbs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT     = 10_000_000;
  localparam int          HOLD_CYCLES     = 600;
  localparam int          SETTLE_CYCLES   = 20;
  localparam int          SEGMENTS        = 12;
  localparam int          SEGMENT_ITEMS   = 30;
  localparam logic [2:0]  BOARD_SIZE_ADDR = 3'd0;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    idx_t column;
    idx_t queen_row;
    logic found;
    logic last;
  } answer_word_t;

  typedef struct {
    logic [3:0]   size;
    idx_t         start;
    bit           typed;
    answer_word_t word;
  } probe_t;

  localparam answer_word_t SINGLE_WORD = '{3'd0, 3'd0, 1'b1, 1'b1};
  localparam answer_word_t EMPTY_WORD  = '{3'd0, 3'd0, 1'b0, 1'b1};
  localparam answer_word_t NO_WORD     = '{3'd0, 3'd0, 1'b0, 1'b0};

  localparam int PROBES = 22;
  probe_t probes [PROBES] = '{
    '{4'd8,  3'd0, 1'b0, NO_WORD},
    '{4'd8,  3'd7, 1'b0, NO_WORD},
    '{4'd8,  3'd3, 1'b0, NO_WORD},
    '{4'd1,  3'd0, 1'b1, SINGLE_WORD},
    '{4'd1,  3'd7, 1'b1, SINGLE_WORD},
    '{4'd0,  3'd5, 1'b1, SINGLE_WORD},
    '{4'd2,  3'd0, 1'b1, EMPTY_WORD},
    '{4'd2,  3'd1, 1'b1, EMPTY_WORD},
    '{4'd3,  3'd2, 1'b1, EMPTY_WORD},
    '{4'd3,  3'd7, 1'b1, EMPTY_WORD},
    '{4'd4,  3'd0, 1'b0, NO_WORD},
    '{4'd4,  3'd3, 1'b0, NO_WORD},
    '{4'd4,  3'd6, 1'b0, NO_WORD},
    '{4'd5,  3'd1, 1'b0, NO_WORD},
    '{4'd5,  3'd6, 1'b0, NO_WORD},
    '{4'd6,  3'd2, 1'b0, NO_WORD},
    '{4'd6,  3'd5, 1'b0, NO_WORD},
    '{4'd7,  3'd4, 1'b0, NO_WORD},
    '{4'd7,  3'd7, 1'b0, NO_WORD},
    '{4'd15, 3'd7, 1'b0, NO_WORD},
    '{4'd9,  3'd0, 1'b0, NO_WORD},
    '{4'd8,  3'd5, 1'b0, NO_WORD}
  };

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [2:0]  start_column = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [2:0]  column;
  logic [2:0]  queen_row;
  logic        found;
  logic        last;

  answer_word_t expected_words [$];
  logic [3:0]   board_size_reg = 4'd8;
  idle_mode_e   idle_mode      = IDLE_NONE;
  int           error_count    = 0;
  int           cycle_count    = 0;
  int           hold_token     = 0;
  int           hold_seen      = 0;
  int           hold_left      = 0;

  n_queens_backtrack_solver dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .start_column (start_column),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .column       (column),
    .queen_row    (queen_row),
    .found        (found),
    .last         (last)
  );

  always #4 clk = ~clk;

  function automatic void solve_placement(input logic [3:0] size_reg, input idx_t sc);
    int           n, start, depth, col, r, next_row;
    bit           row_taken [MAX_N];
    bit           sum_taken [DIAG_N];
    bit           diff_taken [DIAG_N];
    int           chosen [MAX_N];
    int           row_at [MAX_N];
    bit           solved;
    answer_word_t w;
    n = size_reg;
    if (n == 0) n = 1;
    if (n > MAX_N) n = MAX_N;
    start = sc % n;
    for (int i = 0; i < MAX_N; i++) begin
      row_taken[i] = 0;
      chosen[i] = 0;
    end
    for (int i = 0; i < DIAG_N; i++) begin
      sum_taken[i] = 0;
      diff_taken[i] = 0;
    end
    depth = 0;
    next_row = 0;
    solved = 0;
    while (1) begin
      if (depth >= n) begin
        solved = 1;
        break;
      end
      col = (start + depth) % n;
      for (r = next_row; r < n; r++)
        if (!row_taken[r] && !sum_taken[r + col] && !diff_taken[r + n - 1 - col]) break;
      if (r < n) begin
        row_taken[r] = 1;
        sum_taken[r + col] = 1;
        diff_taken[r + n - 1 - col] = 1;
        chosen[depth] = r;
        depth++;
        next_row = 0;
      end else begin
        if (depth == 0) break;
        depth--;
        col = (start + depth) % n;
        r = chosen[depth];
        row_taken[r] = 0;
        sum_taken[r + col] = 0;
        diff_taken[r + n - 1 - col] = 0;
        next_row = r + 1;
      end
    end
    if (!solved) begin
      expected_words.push_back(EMPTY_WORD);
      return;
    end
    for (int i = 0; i < n; i++) row_at[(start + i) % n] = chosen[i];
    for (int c = 0; c < n; c++) begin
      w.column    = idx_t'(c);
      w.queen_row = idx_t'(row_at[c]);
      w.found     = 1'b1;
      w.last      = (c + 1 == n);
      expected_words.push_back(w);
    end
  endfunction

  task automatic send_request(input idx_t sc, input bit typed, input answer_word_t word);
    int gap;
    gap = 0;
    if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH)
      while ($urandom_range(0, 99) < ((idle_mode == IDLE_SEND) ? 56 : 21)) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    start_column <= sc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (typed) expected_words.push_back(word);
    else solve_placement(board_size_reg, sc);
  endtask

  task automatic drain_answers(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_board_size(input logic [3:0] value);
    drain_answers(SETTLE_CYCLES);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BOARD_SIZE_ADDR;
    pwdata  <= {28'($urandom_range(0, 32'h0fff_ffff)), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board_size_reg = value;
    @(posedge clk);
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH) begin
      out_stall <= ($urandom_range(0, 99) < ((idle_mode == IDLE_RECV) ? 56 : 21));
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    answer_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word column %0d queen_row %0d found %0d last %0d",
                 $time, column, queen_row, found, last);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        check_field("column", int'(want.column), int'(column));
        check_field("queen_row", int'(want.queen_row), int'(queen_row));
        check_field("found", int'(want.found), int'(found));
        check_field("last", int'(want.last), int'(last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, expected_words.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [3:0] seg_size;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < PROBES; i++) begin
      if (probes[i].size != board_size_reg) write_board_size(probes[i].size);
      send_request(probes[i].start, probes[i].typed, probes[i].word);
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if ($urandom_range(0, 9) < 6) seg_size = 4'($urandom_range(4, 8));
      else seg_size = 4'($urandom_range(0, 15));
      write_board_size(seg_size);
      idle_mode = idle_mode_e'(seg / 3);
      for (int k = 0; k < SEGMENT_ITEMS; k++) begin
        if (seg == 4 && k == 5) hold_token <= hold_token + 1;
        if (seg == 7 && k == 15) drain_answers(0);
        send_request(idx_t'($urandom_range(0, 7)), 1'b0, NO_WORD);
      end
    end

    drain_answers(SETTLE_CYCLES * 3);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
